// ----- rtl/fir_pkg.sv -----
// Shared types and constants for the FIR filter.
`timescale 1ns / 1ps
package fir_pkg;

  // Default sizes of the filter.
  localparam int unsigned MAX_TAPS_DEF    = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned COEFF_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int unsigned IDX_BITS      = 6;
  localparam int unsigned OUT_BITS      = 38;
  localparam int unsigned OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned TAPS_REG_BITS = 7;

  localparam logic [TAPS_REG_BITS-1:0] TAPS_RESET = TAPS_REG_BITS'(64);

  // Item kinds carried on tuser.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEFF  = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StAlign,
    StMult,
    StSum
  } state_e;

  // Per-cycle commands from the sequencer to every cell.
  typedef struct packed {
    logic shift_sample;  // shift the delay line by one sample
    logic coef_we;       // write one coefficient
    logic rotate;        // rotate the coefficient ring by one cell
    logic load_prod;     // capture the masked product in each cell
  } ctrl_t;

endpackage

// ----- rtl/fir_cell.sv -----
// One cell of the filter chain: a delay-line tap, a coefficient slot, a multiplier and an adder.
`timescale 1ns / 1ps
module fir_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned MAX_TAPS    = fir_pkg::MAX_TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEFF_BITS  = fir_pkg::COEFF_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fir_pkg::ctrl_t                        ctrl_i,
  input  logic [$clog2(MAX_TAPS+1)-1:0]         taps_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  output logic signed [SAMPLE_BITS-1:0]         sample_o,
  input  logic signed [COEFF_BITS-1:0]          coef_i,
  output logic signed [COEFF_BITS-1:0]          coef_o,
  input  logic [fir_pkg::IDX_BITS-1:0]          wr_index_i,
  input  logic signed [COEFF_BITS-1:0]          wr_value_i,
  input  logic signed [fir_pkg::OUT_BITS-1:0]   psum_i,
  output logic signed [fir_pkg::OUT_BITS-1:0]   psum_o
);
  import fir_pkg::*;

  // At rest this slot holds the coefficient for tap MAX_TAPS-1-IDX.
  localparam int unsigned CoefK = MAX_TAPS - 1 - IDX;

  logic signed [SAMPLE_BITS-1:0]            sample_q;
  logic signed [COEFF_BITS-1:0]             coef_q;
  logic signed [SAMPLE_BITS+COEFF_BITS-1:0] prod;
  logic signed [OUT_BITS-1:0]               prod_q;
  logic signed [OUT_BITS-1:0]               psum_d, psum_q;
  logic                                     wr_hit;
  logic                                     in_window;

  assign wr_hit    = ctrl_i.coef_we && (32'(wr_index_i) == 32'(CoefK));
  assign in_window = 32'(IDX) < 32'(taps_i);

  // Delay-line tap and coefficient slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      coef_q   <= '0;
    end else begin
      if (ctrl_i.shift_sample) begin
        sample_q <= sample_i;
      end
      if (wr_hit) begin
        coef_q <= wr_value_i;
      end else if (ctrl_i.rotate) begin
        coef_q <= coef_i;
      end
    end
  end

  // Product of the aligned pair, zero outside the active window.
  assign prod = sample_q * coef_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_prod) begin
      prod_q <= in_window ? OUT_BITS'(prod) : '0;
    end
  end

  // Partial sum ripples one cell toward the chain head each cycle.
  assign psum_d = prod_q + psum_i;

  always_ff @(posedge clk_i) begin
    psum_q <= psum_d;
  end

  assign sample_o = sample_q;
  assign coef_o   = coef_q;
  assign psum_o   = psum_q;

endmodule

// ----- rtl/fir_ctrl.sv -----
// Sequencer of the FIR filter: tap register, ring alignment, sum timing and output register.
`timescale 1ns / 1ps
module fir_ctrl #(
  parameter int unsigned MAX_TAPS = fir_pkg::MAX_TAPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fir_pkg::TAPS_REG_BITS-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  output fir_pkg::ctrl_t                      ctrl_o,
  output logic [$clog2(MAX_TAPS+1)-1:0]       taps_o,
  input  logic signed [fir_pkg::OUT_BITS-1:0] psum_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fir_pkg::OUT_BITS-1:0] out_data_o
);
  import fir_pkg::*;

  localparam int unsigned TapW = $clog2(MAX_TAPS + 1);
  localparam int unsigned RotW = $clog2(MAX_TAPS);
  localparam int unsigned CntW = $clog2(MAX_TAPS + 1);
  localparam logic [TapW-1:0] TapsMax = TapW'(MAX_TAPS);
  localparam logic [RotW-1:0] RotLast = RotW'(MAX_TAPS - 1);
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_TAPS);

  state_e                     state_d, state_q;
  logic [TAPS_REG_BITS-1:0]   taps_q;
  logic [TapW-1:0]            taps_eff;
  logic [TapW-1:0]            gap;
  logic [RotW-1:0]            shift;
  logic [RotW-1:0]            rot_d, rot_q;
  logic [CntW-1:0]            cnt_d, cnt_q;
  logic                       out_free;
  logic                       out_load;
  logic                       out_valid_q;
  logic signed [OUT_BITS-1:0] out_data_q;

  // Tap count register; writes are taken at any time.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= TAPS_RESET;
    end else if (cfg_valid_i) begin
      taps_q <= cfg_data_i;
    end
  end

  // Clamp to the chain length and work out how far the ring must turn.
  assign taps_eff = (32'(taps_q) > 32'(MAX_TAPS)) ? TapsMax : TapW'(taps_q);
  assign gap      = TapsMax - taps_eff;
  assign shift    = (gap == TapsMax) ? '0 : RotW'(gap);
  assign taps_o   = taps_eff;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && (mode_i == MODE_SAMPLE)) begin
          state_d = StAlign;
        end
      end
      StAlign: begin
        if (rot_q == shift) begin
          state_d = StMult;
        end
      end
      StMult: begin
        state_d = StSum;
      end
      StSum: begin
        if ((cnt_q == CntLast) && out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o          = 1'b0;
    ctrl_o              = '0;
    out_load            = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o          = 1'b1;
        ctrl_o.shift_sample = in_valid_i && (mode_i == MODE_SAMPLE);
        ctrl_o.coef_we      = in_valid_i && (mode_i == MODE_COEFF);
      end
      StAlign: begin
        ctrl_o.rotate = (rot_q != shift);
      end
      StMult: begin
        ctrl_o.load_prod = 1'b1;
      end
      StSum: begin
        ctrl_o.rotate = (rot_q != '0);
        out_load      = (cnt_q == CntLast) && out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Ring position and sum cycle counter.
  always_comb begin
    rot_d = rot_q;
    if (ctrl_o.rotate) begin
      rot_d = (rot_q == RotLast) ? '0 : rot_q + RotW'(1);
    end
    cnt_d = cnt_q;
    if (state_q == StMult) begin
      cnt_d = '0;
    end else if ((state_q == StSum) && (cnt_q != CntLast)) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rot_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      rot_q   <= rot_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output register decouples the result from the next sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= psum_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The coefficient ring is back at rest whenever new items are taken.
  a_ring_home_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> rot_q == '0)
    else $error("coefficient ring not at rest in idle");

  // Products are captured only with the ring turned by the right amount.
  a_ring_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMult |-> rot_q == shift)
    else $error("coefficient ring misaligned at product capture");

  // A result appears only after the full ripple of the partial sums.
  a_result_after_ripple: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StSum && cnt_q == CntLast))
    else $error("result loaded before the sum settled");

  // Ring position stays inside the chain.
  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_q <= RotLast)
    else $error("ring position out of range");

endmodule

// ----- rtl/fir_filter_top.sv -----
// Top level of the streaming FIR filter: sequencer and a chain of tap cells.
`timescale 1ns / 1ps
// A direct-form FIR filter built as a chain of MAX_TAPS cells, each holding one delay-line
// sample and one coefficient. An item with tuser 1 writes one coefficient. An item with
// tuser 0 shifts a sample into the delay line and produces one exact 38-bit sum over the
// newest taps samples (taps is the configured tap count, clamped to MAX_TAPS). The
// coefficient ring first turns MAX_TAPS - taps cells to line up with the window, every cell
// then multiplies, and the partial sums ripple one cell per cycle to the head of the chain;
// no new item is taken until the sum has been loaded into the output register. The finished
// sum waits in an output register, so the next item is taken even while the result has not
// been transferred. The tap count register resets to 64 and the delay line and coefficients
// reset to zero.
module fir_filter_top #(
  parameter int unsigned MAX_TAPS    = fir_pkg::MAX_TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEFF_BITS  = fir_pkg::COEFF_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // Tap count register write channel.
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [fir_pkg::TAPS_REG_BITS-1:0]          cfg_data_i,
  // Input stream.
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // tdata: sample, coeff_index, coeff_value (lowest bits first), zero padded to bytes
  input  logic [((SAMPLE_BITS + fir_pkg::IDX_BITS + COEFF_BITS + 7) / 8) * 8 - 1:0]
                                                     s_axis_tdata,
  // tuser: mode (0 sample, 1 coefficient write)
  input  logic                                       s_axis_tuser,
  // Output stream.
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // tdata: filtered in the low 38 bits, zero padded to bytes
  output logic [fir_pkg::OUT_TDATA_W-1:0]            m_axis_tdata
);
  import fir_pkg::*;

  localparam int unsigned TapW     = $clog2(MAX_TAPS + 1);
  localparam int unsigned IdxLo    = SAMPLE_BITS;
  localparam int unsigned ValLo    = SAMPLE_BITS + IDX_BITS;

  ctrl_t                         ctrl;
  logic [TapW-1:0]               taps_eff;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [IDX_BITS-1:0]           in_index;
  logic signed [COEFF_BITS-1:0]  in_value;
  logic signed [OUT_BITS-1:0]    head_sum;
  logic signed [OUT_BITS-1:0]    result;

  logic signed [SAMPLE_BITS-1:0] sample_chain [MAX_TAPS];
  logic signed [COEFF_BITS-1:0]  coef_chain   [MAX_TAPS];
  logic signed [OUT_BITS-1:0]    psum_chain   [MAX_TAPS + 1];

  // Unpack the input item.
  assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_index  = s_axis_tdata[IdxLo +: IDX_BITS];
  assign in_value  = s_axis_tdata[ValLo +: COEFF_BITS];

  fir_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .ctrl_o      (ctrl),
    .taps_o      (taps_eff),
    .psum_i      (head_sum),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (result)
  );

  // The tail of the chain feeds a zero partial sum.
  assign psum_chain[MAX_TAPS] = '0;
  assign head_sum             = psum_chain[0];

  // Samples move away from cell 0; coefficients rotate toward cell 0 around a ring.
  for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] sample_in;

    if (g == 0) begin : g_head
      assign sample_in = in_sample;
    end else begin : g_body
      assign sample_in = sample_chain[g-1];
    end

    fir_cell #(
      .IDX         (g),
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEFF_BITS  (COEFF_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .taps_i     (taps_eff),
      .sample_i   (sample_in),
      .sample_o   (sample_chain[g]),
      .coef_i     (coef_chain[(g + 1) % MAX_TAPS]),
      .coef_o     (coef_chain[g]),
      .wr_index_i (in_index),
      .wr_value_i (in_value),
      .psum_i     (psum_chain[g + 1]),
      .psum_o     (psum_chain[g])
    );
  end

  // Pack the result.
  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, result};

endmodule
